// File: hw/rtl/bmf_pkg.sv
// Shared types and constants for the binaural multichannel FIR mixer.
// Used by every module under hw/rtl; depends on nothing else.
package bmf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ACTION_W   = 2;
    localparam int SPEAKER_W  = 3;
    localparam int TAP_IN_W   = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_SPK_W  = 4;
    localparam int CFG_TAPS_W = 10;
    localparam int PROD_W     = 2 * SAMPLE_W;

    // Register indexes of the configuration port.
    typedef enum logic {
        CFG_SPEAKERS = 1'b0,
        CFG_TAPS     = 1'b1
    } t_cfg_index;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clr;     // zero both accumulators
        logic rd_vld;  // memory read data is a term of the sum
    } t_mac_ctrl;

endpackage

// File: hw/rtl/bmf_coef_mem.sv
// Coefficient memory: one word per (channel, tap) holding the left and right lanes.
// Lane-select write, registered read of both lanes. Depends on bmf_pkg.
module bmf_coef_mem
    import bmf_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [ADDR_W-1:0]                 i_waddr,
    input  logic                              i_wlane,
    input  logic signed [SAMPLE_W-1:0]        i_wdata,
    input  logic                              i_re,
    input  logic [ADDR_W-1:0]                 i_raddr,
    output logic signed [SAMPLE_W-1:0]        o_rdata_l,
    output logic signed [SAMPLE_W-1:0]        o_rdata_r
);

    logic [1:0][SAMPLE_W-1:0] mem [DEPTH];
    logic [1:0][SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr][i_wlane] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata_l = $signed(r_rdata[0]);
    assign o_rdata_r = $signed(r_rdata[1]);

endmodule

// File: hw/rtl/bmf_hist_mem.sv
// Sample history memory: one ring of samples per channel, laid end to end.
// One write port, one registered read port. Depends on bmf_pkg.
module bmf_hist_mem
    import bmf_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic signed [SAMPLE_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic signed [SAMPLE_W-1:0]  o_rdata
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = $signed(r_rdata);

endmodule

// File: hw/rtl/bmf_mac.sv
// Two-lane multiply-accumulate with Q2.30 to Q1.15 rounding and saturation.
// Products are registered before the accumulate. Depends on bmf_pkg.
module bmf_mac
    import bmf_pkg::*;
#(
    parameter int ACC_W = 49
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mac_ctrl                   i_ctrl,
    input  logic signed [SAMPLE_W-1:0]  i_coef_l,
    input  logic signed [SAMPLE_W-1:0]  i_coef_r,
    input  logic signed [SAMPLE_W-1:0]  i_hist,
    output logic                        o_busy,
    output logic signed [SAMPLE_W-1:0]  o_left,
    output logic signed [SAMPLE_W-1:0]  o_right,
    output logic                        o_clipped
);

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] POS_LIM  = ACC_W'(64'd1 << 30);
    localparam logic signed [ACC_W-1:0] NEG_LIM  = -POS_LIM;

    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc_l;
    logic signed [ACC_W-1:0]  r_acc_r;
    logic [SAMPLE_W:0]        rs_l;
    logic [SAMPLE_W:0]        rs_r;

    // Returns {saturated, value}; the shift floors, so adding half an LSB rounds half up.
    function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] s;
        r = a + HALF_LSB;
        s = r >>> 15;
        if (r >= POS_LIM) begin
            return {1'b1, 16'h7FFF};
        end else if (r < NEG_LIM) begin
            return {1'b1, 16'h8000};
        end else begin
            return {1'b0, s[SAMPLE_W-1:0]};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        r_prod_l <= PROD_W'(i_coef_l * i_hist);
        r_prod_r <= PROD_W'(i_coef_r * i_hist);
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.rd_vld;
        end
        if (i_ctrl.clr) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_prod_vld) begin
            r_acc_l <= r_acc_l + ACC_W'(r_prod_l);
            r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
        end
    end

    always_comb begin
        rs_l = round_sat(r_acc_l);
        rs_r = round_sat(r_acc_r);
    end

    assign o_busy    = r_prod_vld;
    assign o_left    = $signed(rs_l[SAMPLE_W-1:0]);
    assign o_right   = $signed(rs_r[SAMPLE_W-1:0]);
    assign o_clipped = rs_l[SAMPLE_W] | rs_r[SAMPLE_W];

endmodule

// File: hw/rtl/binaural_multichannel_fir_top.sv
// Top level of the binaural multichannel FIR mixer: sequencer, configuration
// registers and output register. Uses bmf_pkg, bmf_coef_mem, bmf_hist_mem, bmf_mac.
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_action i_speaker i_ear i_tap i_value
//  output   out        o_out_valid / i_out_stall o_left_sample o_right_sample o_clipped
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// A load, a sample that does not close a frame, or an ignored item is taken without leaving ST_IDLE.
// A frame-closing sample steps through speakers * taps terms of one read and two MACs each
// (one coefficient-memory read gives both ears), then drains the MAC pipeline.
// After reset and after a clear item, the history is swept one entry a cycle:
// all MAX_SPEAKERS * MAX_TAPS entries (4096 at the defaults) are zeroed with the input stalled.
// A result waits in the output register; the next frame then stalls until it is free.
module binaural_multichannel_fir_top
    import bmf_pkg::*;
#(
    parameter int MAX_SPEAKERS = 8,
    parameter int MAX_TAPS     = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ACTION_W-1:0]         i_action,
    input  logic [SPEAKER_W-1:0]        i_speaker,
    input  logic                        i_ear,
    input  logic [TAP_IN_W-1:0]         i_tap,
    input  logic signed [SAMPLE_W-1:0]  i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [SAMPLE_W-1:0]  o_left_sample,
    output logic signed [SAMPLE_W-1:0]  o_right_sample,
    output logic                        o_clipped,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int DEPTH  = MAX_SPEAKERS * MAX_TAPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TAP_W  = $clog2(MAX_TAPS);
    localparam int CH_W   = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;
    localparam int ACC_W  = PROD_W + ADDR_W;

    t_state                    r_state, n_state;
    logic [CFG_SPK_W-1:0]      r_cfg_spk;
    logic [CFG_TAPS_W-1:0]     r_cfg_taps;
    logic [TAP_W-1:0]          r_wp, n_wp;
    logic [CH_W-1:0]           r_chan, n_chan;
    logic [TAP_W-1:0]          r_tap, n_tap;
    logic [TAP_W-1:0]          r_hpos, n_hpos;
    logic [ADDR_W-1:0]         r_clr_cnt, n_clr_cnt;
    logic                      r_rd_vld;
    logic                      r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_left;
    logic signed [SAMPLE_W-1:0] r_out_right;
    logic                      r_out_clip;

    logic [CH_W-1:0]           last_chan;
    logic [TAP_W-1:0]          last_tap;
    logic                      in_acc;
    logic                      spk_ok;
    logic                      tap_ok;
    logic                      load_out;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_caddr;
    logic [ADDR_W-1:0]         rd_haddr;
    logic                      hist_we;
    logic [ADDR_W-1:0]         hist_waddr;
    logic signed [SAMPLE_W-1:0] hist_wdata;
    logic                      coef_we;
    logic [ADDR_W-1:0]         coef_waddr;
    t_mac_ctrl                 mac_ctrl;

    logic signed [SAMPLE_W-1:0] coef_l;
    logic signed [SAMPLE_W-1:0] coef_r;
    logic signed [SAMPLE_W-1:0] hist_rd;
    logic                      mac_busy;
    logic signed [SAMPLE_W-1:0] mac_left;
    logic signed [SAMPLE_W-1:0] mac_right;
    logic                      mac_clip;

    // Register values outside their range are clamped when used; the raw bits stay.
    always_comb begin
        if (r_cfg_spk == '0) begin
            last_chan = '0;
        end else if (32'(r_cfg_spk) > MAX_SPEAKERS) begin
            last_chan = CH_W'(MAX_SPEAKERS - 1);
        end else begin
            last_chan = CH_W'(r_cfg_spk - 4'd1);
        end
        if (r_cfg_taps == '0) begin
            last_tap = '0;
        end else if (32'(r_cfg_taps) > MAX_TAPS) begin
            last_tap = TAP_W'(MAX_TAPS - 1);
        end else begin
            last_tap = TAP_W'(r_cfg_taps - 10'd1);
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign spk_ok      = 32'(i_speaker) < MAX_SPEAKERS;
    assign tap_ok      = 32'(i_tap) < MAX_TAPS;
    assign coef_waddr  = ADDR_W'(32'(i_speaker) * MAX_TAPS + 32'(i_tap));
    assign rd_caddr    = ADDR_W'(32'(r_chan) * MAX_TAPS + 32'(r_tap));
    assign rd_haddr    = ADDR_W'(32'(r_chan) * MAX_TAPS + 32'(r_hpos));

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_chan       = r_chan;
        n_tap        = r_tap;
        n_hpos       = r_hpos;
        n_clr_cnt    = r_clr_cnt;
        hist_we      = 1'b0;
        hist_waddr   = r_clr_cnt;
        hist_wdata   = '0;
        coef_we      = 1'b0;
        rd_en        = 1'b0;
        load_out     = 1'b0;
        mac_ctrl.clr = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                hist_we = 1'b1;
                if (r_clr_cnt == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_action'(i_action))
                        ACT_LOAD: begin
                            coef_we = spk_ok && tap_ok;
                        end
                        ACT_SAMPLE: begin
                            if (spk_ok) begin
                                hist_we    = 1'b1;
                                hist_waddr = ADDR_W'(32'(i_speaker) * MAX_TAPS + 32'(r_wp));
                                hist_wdata = i_value;
                                if (32'(i_speaker) == 32'(last_chan)) begin
                                    n_state      = ST_MAC;
                                    n_chan       = '0;
                                    n_tap        = '0;
                                    n_hpos       = r_wp;
                                    mac_ctrl.clr = 1'b1;
                                end
                            end
                        end
                        ACT_CLEAR: begin
                            n_state   = ST_CLEAR;
                            n_clr_cnt = '0;
                            n_wp      = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MAC: begin
                rd_en = 1'b1;
                if (r_tap == last_tap) begin
                    n_tap  = '0;
                    n_hpos = r_wp;
                    if (r_chan == last_chan) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_chan = r_chan + 1'b1;
                    end
                end else begin
                    n_tap  = r_tap + 1'b1;
                    // Walk back through the ring, wrapping below slot zero.
                    n_hpos = (r_hpos == '0) ? TAP_W'(MAX_TAPS - 1) : r_hpos - 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !mac_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_wp     = (r_wp == TAP_W'(MAX_TAPS - 1)) ? '0 : r_wp + 1'b1;
                    n_state  = ST_IDLE;
                end
            end
        endcase
        mac_ctrl.rd_vld = r_rd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cfg_spk   <= CFG_SPK_W'(8);
            r_cfg_taps  <= CFG_TAPS_W'(512);
            r_wp        <= '0;
            r_chan      <= '0;
            r_tap       <= '0;
            r_hpos      <= '0;
            r_clr_cnt   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_chan    <= n_chan;
            r_tap     <= n_tap;
            r_hpos    <= n_hpos;
            r_clr_cnt <= n_clr_cnt;
            r_rd_vld  <= rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_SPEAKERS: r_cfg_spk  <= i_cfg_data[CFG_SPK_W-1:0];
                    CFG_TAPS:     r_cfg_taps <= i_cfg_data[CFG_TAPS_W-1:0];
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_left  <= mac_left;
            r_out_right <= mac_right;
            r_out_clip  <= mac_clip;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_out_left;
    assign o_right_sample = r_out_right;
    assign o_clipped      = r_out_clip;

    bmf_coef_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_coef_mem (
        .i_clk     (i_clk),
        .i_we      (coef_we),
        .i_waddr   (coef_waddr),
        .i_wlane   (i_ear),
        .i_wdata   (i_value),
        .i_re      (rd_en),
        .i_raddr   (rd_caddr),
        .o_rdata_l (coef_l),
        .o_rdata_r (coef_r)
    );

    bmf_hist_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_hist_mem (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_haddr),
        .o_rdata (hist_rd)
    );

    bmf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mac_ctrl),
        .i_coef_l  (coef_l),
        .i_coef_r  (coef_r),
        .i_hist    (hist_rd),
        .o_busy    (mac_busy),
        .o_left    (mac_left),
        .o_right   (mac_right),
        .o_clipped (mac_clip)
    );

endmodule
